>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent, outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/fra_pkg.sv
// types and codes for the fraction arithmetic block
// no dependencies
package fra_pkg;

  localparam int unsigned NumW = 33;
  localparam int unsigned DenW = 32;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIV0    = 2'd1,
    ST_ZERODEN = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] a_num;
    logic signed [15:0] a_den;
    logic signed [15:0] b_num;
    logic signed [15:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [NumW-1:0] res_num;
    logic signed [DenW-1:0] res_den;
    logic [1:0]             status;
  } out_item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SUM,
    B_GCD,
    B_DIVN,
    B_DIVD,
    B_OUT
  } bstate_t;

endpackage

>>> rtl/core/fra_front.sv
// front end: takes items, checks for the error cases, queues them with their operands
// depends on fra_pkg
module fra_front
  import fra_pkg::*;
#(
  parameter int unsigned OperandWidth = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  in_item_t               in_item,
  input  logic                   push,
  output logic                   full,
  output logic                   q_valid,
  input  logic                   q_take,
  output logic [1:0]             q_status,
  output logic [1:0]             q_mode,
  output logic [4*OperandWidth-1:0] q_ops
);
  // two-entry queue of classified items
  logic [1:0]                    vld;
  logic [1:0]                    st [2];
  logic [1:0]                    md [2];
  logic [4*OperandWidth-1:0]     ops [2];
  logic                          wp, rp;
  logic [1:0]                    st_in;
  logic [OperandWidth-1:0]       an, ad, bn, bd;
  logic                          do_push, do_pop;

  assign an = OperandWidth'($unsigned(in_item.a_num));
  assign ad = OperandWidth'($unsigned(in_item.a_den));
  assign bn = OperandWidth'($unsigned(in_item.b_num));
  assign bd = OperandWidth'($unsigned(in_item.b_den));

  always_comb begin
    if (ad == '0 || bd == '0) st_in = ST_ZERODEN;
    else if (in_item.mode == MODE_DIV && bn == '0) st_in = ST_DIV0;
    else st_in = ST_OK;
  end

  assign full     = vld[wp];
  assign do_push  = push && !full;
  assign q_valid  = vld[rp];
  assign do_pop   = q_take && q_valid;
  assign q_status = st[rp];
  assign q_mode   = md[rp];
  assign q_ops    = ops[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (do_push) begin
        vld[wp] <= 1'b1;
        wp      <= ~wp;
      end
      if (do_pop) begin
        vld[rp] <= 1'b0;
        rp      <= ~rp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      st[wp]  <= st_in;
      md[wp]  <= in_item.mode;
      ops[wp] <= {an, ad, bn, bd};
    end
  end

endmodule

>>> rtl/core/fra_back.sv
// back end: cross products, euclid gcd by remainders from a restoring divider, and the two divisions
// depends on fra_pkg and assert_macros.svh
`include "assert_macros.svh"
module fra_back
  import fra_pkg::*;
#(
  parameter int unsigned OperandWidth = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_take,
  input  logic [1:0]                q_status,
  input  logic [1:0]                q_mode,
  input  logic [4*OperandWidth-1:0] q_ops,
  output logic                      empty,
  input  logic                      pop,
  output out_item_t                 out_item
);
  localparam int unsigned W  = OperandWidth;
  localparam int unsigned PW = 2*W + 1;
  localparam int unsigned CW = $clog2(PW + 1);

  bstate_t state, state_next;

  logic [PW-1:0]  p0, p1, dmag;
  logic           p0n, p1n, dneg;
  logic [PW-1:0]  nmag;
  logic           nneg;
  logic [PW-1:0]  gx, gy;
  // shared restoring divider: rem/quo with divisor dv
  logic [PW-1:0]  dv, quo, rem, dend;
  logic [CW-1:0]  cnt;
  logic           dbusy;
  logic [PW-1:0]  gval;
  logic [1:0]     md;
  logic           obuf_v;
  out_item_t      obuf;

  logic [W-1:0]   an, ad, bn, bd;
  logic [W-1:0]   m1a, m1b, m2a, m2b, m3a, m3b;
  logic [PW-1:0]  pr1, pr2, pr3;
  logic [PW:0]    trial;

  assign {an, ad, bn, bd} = q_ops;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    m1a = an; m1b = bd; m2a = bn; m2b = ad; m3a = ad; m3b = bd;
    unique case (mode_t'(q_mode))
      MODE_MUL: begin m1b = bn; end
      MODE_DIV: begin m3b = bn; end
      default: ;
    endcase
  end
  assign pr1 = PW'(mag(m1a)) * PW'(mag(m1b));
  assign pr2 = PW'(mag(m2a)) * PW'(mag(m2b));
  assign pr3 = PW'(mag(m3a)) * PW'(mag(m3b));

  assign trial = {rem[PW-2:0], dend[PW-1]} - {1'b0, dv};
  assign gval  = (gx == '0) ? PW'(1) : gx;

  assign q_take = (state == B_IDLE) && q_valid && !(q_status != ST_OK && obuf_v);
  assign empty  = !obuf_v;
  assign out_item = obuf;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (q_valid && q_status == ST_OK) state_next = B_MUL;
      B_MUL:  state_next = B_SUM;
      B_SUM:  state_next = B_GCD;
      B_GCD:  if (gy == '0 && !dbusy) state_next = B_DIVN;
      B_DIVN: if (dbusy && cnt == CW'(1)) state_next = B_DIVD;
      B_DIVD: if (dbusy && cnt == CW'(1)) state_next = B_OUT;
      B_OUT:  if (!obuf_v) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      obuf_v <= 1'b0;
      dbusy  <= 1'b0;
      cnt    <= '0;
    end else begin
      state <= state_next;
      if (pop && obuf_v) obuf_v <= 1'b0;
      if (q_take && q_status != ST_OK) obuf_v <= 1'b1;
      if (state == B_OUT && !obuf_v) obuf_v <= 1'b1;
      if (dbusy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) dbusy <= 1'b0;
      end else if ((state == B_GCD && gy != '0) ||
                   (state == B_GCD && gy == '0) || (state == B_DIVD)) begin
        dbusy <= 1'b1;
        cnt   <= CW'(PW);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_take && q_status != ST_OK) begin
      obuf.res_num <= '0;
      obuf.res_den <= '0;
      obuf.status  <= q_status;
    end
    if (state == B_IDLE && q_take) begin
      md  <= q_mode;
      p0  <= pr1;
      p0n <= (pr1 != '0) && (m1a[W-1] != m1b[W-1]);
      p1  <= pr2;
      p1n <= (pr2 != '0) && ((m2a[W-1] != m2b[W-1]) ^ (q_mode == MODE_SUB));
      dmag <= pr3;
      dneg <= (pr3 != '0) && (m3a[W-1] != m3b[W-1]);
    end
    if (state == B_MUL) begin
      if (md == MODE_MUL || md == MODE_DIV) begin
        nmag <= p0; nneg <= p0n;
      end else if (p0n == p1n) begin
        nmag <= p0 + p1; nneg <= p0n;
      end else if (p0 >= p1) begin
        nmag <= p0 - p1; nneg <= p0n && (p0 != p1);
      end else begin
        nmag <= p1 - p0; nneg <= p1n;
      end
    end
    if (state == B_SUM) begin
      gx <= nmag;
      gy <= dmag;
    end
    // start a division: gcd step x%y, or the reductions by g
    if (!dbusy && state == B_GCD) begin
      if (gy != '0) begin dend <= gx; dv <= gy; end
      else begin dend <= nmag; dv <= gval; end
      rem <= '0; quo <= '0;
    end
    if (!dbusy && state == B_DIVD) begin
      dend <= dmag; dv <= gval; rem <= '0; quo <= '0;
    end
    if (dbusy) begin
      dend <= {dend[PW-2:0], 1'b0};
      if (!trial[PW]) begin
        rem <= trial[PW-1:0];
        quo <= {quo[PW-2:0], 1'b1};
      end else begin
        rem <= {rem[PW-2:0], dend[PW-1]};
        quo <= {quo[PW-2:0], 1'b0};
      end
      if (cnt == CW'(1)) begin
        if (state == B_GCD) begin
          gx <= dv;
          gy <= trial[PW] ? {rem[PW-2:0], dend[PW-1]} : trial[PW-1:0];
        end else if (state == B_DIVN) begin
          nmag <= trial[PW] ? {quo[PW-2:0], 1'b0} : {quo[PW-2:0], 1'b1};
        end else begin
          dmag <= trial[PW] ? {quo[PW-2:0], 1'b0} : {quo[PW-2:0], 1'b1};
        end
      end
    end
    if (state == B_OUT && !obuf_v) begin
      obuf.res_num <= NumW'(nneg ? (~{1'b0, nmag} + 1'b1) : {1'b0, nmag});
      obuf.res_den <= DenW'(dneg ? (~{1'b0, dmag} + 1'b1) : {1'b0, dmag});
      obuf.status  <= ST_OK;
    end
  end

  `ASSERT_IMPL(a_take_idle, clk, rst, q_take, state == B_IDLE, "take outside idle")
  `ASSERT_IMPL(a_div_cnt, clk, rst, dbusy, cnt != '0, "divider count lost")
  `ASSERT_NEXT(a_out_set, clk, rst, state == B_OUT && !obuf_v, obuf_v, "result dropped")

endmodule

>>> rtl/core/fraction_arith_reduce.sv
// top level of the fraction arithmetic block with gcd reduction
// depends on fra_pkg, fra_front, fra_back
//
// channel  | handshake    | payload
// input    | push / full  | in_item  (mode, a_num, a_den, b_num, b_den)
// result   | pop / empty  | out_item (res_num, res_den, status)
//
// an ok item is set up through the mul and sum states, then runs euclid steps
// through one restoring divider, then two reductions through the same divider
// error items bypass the divider and go straight to the output buffer
// rst is synchronous and empties both queues; either side may stall freely
module fraction_arith_reduce
  import fra_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  logic      push,
  output logic      full,
  output out_item_t out_item,
  output logic      empty,
  input  logic      pop
);
  localparam int unsigned W = OPERAND_WIDTH;

  logic              q_valid, q_take;
  logic [1:0]        q_status, q_mode;
  logic [4*W-1:0]    q_ops;

  fra_front #(.OperandWidth(W)) u_front (
    .clk, .rst, .in_item, .push, .full,
    .q_valid, .q_take, .q_status, .q_mode, .q_ops
  );

  fra_back #(.OperandWidth(W)) u_back (
    .clk, .rst, .q_valid, .q_take, .q_status, .q_mode, .q_ops,
    .empty, .pop, .out_item
  );

endmodule

>>> test/testbench.sv
// testbench for fraction_arith_reduce: directed and random fraction requests
// depends on fra_pkg and the fraction_arith_reduce rtl
module testbench;
  import fra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OpW = 16;
  localparam int WatchLimit = 200000;

  logic clk;
  logic rst;
  in_item_t in_item;
  logic push;
  logic full;
  out_item_t out_item;
  logic empty;
  logic pop;

  out_item_t expected_q[$];
  int fails;
  int n_sent;
  int n_got;
  int idle_cnt;
  bit allow_idle;
  bit timed_out;

  fraction_arith_reduce #(.OPERAND_WIDTH(OpW)) i_dut (
    .clk(clk), .rst(rst), .in_item(in_item), .push(push), .full(full),
    .out_item(out_item), .empty(empty), .pop(pop)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // signed products are exact in 64 bits for 16-bit operands
  function automatic out_item_t reduced_fraction(in_item_t r);
    out_item_t o;
    longint an, ad, bn, bd, nv, dv;
    logic [63:0] nm, dm, g;
    an = r.a_num;
    ad = r.a_den;
    bn = r.b_num;
    bd = r.b_den;
    o = '0;
    if (ad == 0 || bd == 0) begin
      o.status = ST_ZERODEN;
      return o;
    end
    if (mode_t'(r.mode) == MODE_DIV && bn == 0) begin
      o.status = ST_DIV0;
      return o;
    end
    case (mode_t'(r.mode))
      MODE_ADD: begin
        nv = an * bd + bn * ad;
        dv = ad * bd;
      end
      MODE_SUB: begin
        nv = an * bd - bn * ad;
        dv = ad * bd;
      end
      MODE_MUL: begin
        nv = an * bn;
        dv = ad * bd;
      end
      default: begin
        nv = an * bd;
        dv = ad * bn;
      end
    endcase
    nm = nv < 0 ? -nv : nv;
    dm = dv < 0 ? -dv : dv;
    g = gcd64(nm, dm);
    if (g == 0) g = 1;
    nm = nm / g;
    dm = dm / g;
    o.res_num = nv < 0 ? -nm : nm;
    o.res_den = dv < 0 ? -dm : dm;
    o.status = ST_OK;
    return o;
  endfunction

  task automatic send_request(in_item_t r);
    int gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item <= r;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_q.push_back(reduced_fraction(r));
    n_sent++;
  endtask

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($signed($urandom_range(0, 20)) - 10);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [15:0] edges[6];
    in_item_t r;
    edges = '{16'sh8000, 16'sh7fff, 16'sd1, -16'sd1, 16'sd0, 16'sd6};
    for (int m = 0; m < 4; m++) begin
      r.mode = 2'(m);
      r.a_num = edges[m];
      r.a_den = edges[(m + 1) % 4];
      r.b_num = edges[(m + 2) % 4];
      r.b_den = edges[(m + 3) % 4];
      send_request(r);
      r = '{2'(m), 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
      send_request(r);
      r = '{2'(m), 16'sh7fff, -16'sd1, 16'sh8000, 16'sh7fff};
      send_request(r);
      // zero numerators and a zero input denominator
      r = '{2'(m), 16'sd0, -16'sd4, 16'sd0, 16'sd6};
      send_request(r);
      r = '{2'(m), 16'sd3, 16'sd0, 16'sd5, 16'sd7};
      send_request(r);
    end
    send_request('{MODE_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd5});
    send_request('{MODE_DIV, 16'sd0, 16'sd4, 16'sd2, 16'sd0});
    send_request('{MODE_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2});
    send_request('{MODE_ADD, 16'sd6, -16'sd9, -16'sd4, 16'sd6});
  endtask

  task automatic test_random(int count);
    in_item_t r;
    for (int k = 0; k < count; k++) begin
      r.mode = 2'($urandom_range(0, 3));
      r.a_num = rand_operand();
      r.a_den = rand_operand();
      r.b_num = rand_operand();
      r.b_den = rand_operand();
      // keep error items rare so most requests go through the divider
      if ($urandom_range(0, 15) != 0) begin
        if (r.a_den == 0) r.a_den = 16'sd1;
        if (r.b_den == 0) r.b_den = -16'sd1;
        if (r.mode == MODE_DIV && r.b_num == 0) r.b_num = 16'sd2;
      end
      send_request(r);
    end
  endtask

  // result checker and consumer stall
  initial begin
    int stall;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        n_got++;
        if (expected_q.size() == 0) begin
          $error("result with no request waiting");
          fails++;
        end else begin
          out_item_t e;
          e = expected_q.pop_front();
          if (out_item.res_num !== e.res_num) begin
            $error("res_num expected %0d actual %0d", e.res_num, out_item.res_num);
            fails++;
          end
          if (out_item.res_den !== e.res_den) begin
            $error("res_den expected %0d actual %0d", e.res_den, out_item.res_den);
            fails++;
          end
          if (out_item.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_item.status);
            fails++;
          end
        end
      end
      if (allow_idle && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 14);
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
    end
  end

  // watchdog on cycles with no accepted request or result
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WatchLimit) begin
        timed_out = 1'b1;
      end
    end
  end

  initial begin
    fails = 0;
    n_sent = 0;
    n_got = 0;
    idle_cnt = 0;
    timed_out = 1'b0;
    allow_idle = 1'b1;
    rst = 1'b1;
    push = 1'b0;
    in_item = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    fork
      begin
        test_directed();
        test_random(560);
        allow_idle = 1'b0;
        test_random(140);
        push <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
      end
      wait (timed_out);
    join_any
    if (timed_out) begin
      $display("tb: failure");
      $finish;
    end else begin
      $display("covered %0d requests, %0d results checked over all four operations",
               n_sent, n_got);
      if (fails == 0 && expected_q.size() == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
      $finish;
    end
  end
endmodule

>>> fraction_arith_reduce.f
+incdir+rtl/core
rtl/core/fra_pkg.sv
rtl/core/fra_front.sv
rtl/core/fra_back.sv
rtl/core/fraction_arith_reduce.sv
test/testbench.sv
